// ===== design/dtg_pkg.sv =====
// Shared types and constants for the DTMF tone generator.
// Used by the channel interfaces, the front, queue and back modules and the checker.
// No dependencies.
`timescale 1ns / 1ps

package dtg_pkg;

    localparam int RATE_W     = 17;
    localparam int MASK_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int SAMPLE_W   = 16;
    localparam int OFFSET_W   = 19;
    localparam int FREQ_W     = 11;
    localparam int ROM_W      = 15;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = FREQ_W + OFFSET_W;
    localparam int FIFO_DEPTH = 2;

    localparam logic [RATE_W-1:0] RATE_RESET   = 17'd44100;
    localparam int                WRAP_SECONDS = 5;
    localparam int                SAMPLE_MAX   = 16384;

    localparam logic [FREQ_W-1:0] ROW_FREQ [4] = '{11'd697, 11'd770, 11'd852, 11'd941};
    localparam logic [FREQ_W-1:0] COL_FREQ [4] = '{11'd1209, 11'd1336, 11'd1477, 11'd1633};

    typedef enum logic {
        REG_SAMPLE_RATE = 1'b0,
        REG_TONE_MASK   = 1'b1
    } cfg_reg_t;

    // One burst as handed from the front to the back.
    typedef struct packed {
        logic [OFFSET_W-1:0] base;
        logic [COUNT_W-1:0]  count;
        logic [FREQ_W-1:0]   row_freq;
        logic [FREQ_W-1:0]   col_freq;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_POS_START,
        BK_POS_WAIT,
        BK_STEP_START,
        BK_STEP_WAIT,
        BK_ROW,
        BK_COL,
        BK_MIX
    } back_state_t;

endpackage

// ===== design/dtg_req_if.sv =====
// Request channel: one transfer carries the length of one burst.
// Depends on dtg_pkg.
`timescale 1ns / 1ps

interface dtg_req_if;
    logic                           valid;
    logic                           ready;
    logic [dtg_pkg::COUNT_W-1:0]    sample_count;

    modport source (output valid, output sample_count, input ready);
    modport sink (input valid, input sample_count, output ready);
endinterface

// ===== design/dtg_smp_if.sv =====
// Sample channel: one transfer carries one mixed sample and its end-of-burst flag.
// Depends on dtg_pkg.
`timescale 1ns / 1ps

interface dtg_smp_if;
    logic                           valid;
    logic                           ready;
    logic [dtg_pkg::SAMPLE_W-1:0]   sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

// ===== design/dtg_front.sv =====
// Front end: configuration registers, request intake, tone selection and the
// running sample counter. Depends on dtg_pkg and dtg_req_if.
`timescale 1ns / 1ps

module dtg_front #(
    parameter int MAX_BURST = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  dtg_pkg::cfg_reg_t                  cfg_index,
    input  logic [dtg_pkg::CFG_DATA_W-1:0]     cfg_data,
    dtg_req_if.sink                            req,
    input  logic                               full,
    output logic                               push,
    output dtg_pkg::cmd_t                      push_cmd,
    output logic [dtg_pkg::RATE_W-1:0]         rate
);
    import dtg_pkg::*;

    localparam int SUM_W = OFFSET_W + 1;

    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    logic                accept;
    logic [COUNT_W-1:0]  count_clamped;
    logic [SUM_W-1:0]    off_sum;
    logic [SUM_W-1:0]    span;

    // The lowest set bit of a half picks its tone; no set bit means silence.
    function automatic logic [FREQ_W-1:0] pick_freq(input logic [3:0] bits, input logic col);
        logic [FREQ_W-1:0] f;
        f = '0;
        for (int k = 3; k >= 0; k--) begin
            if (bits[k]) begin
                f = col ? COL_FREQ[k] : ROW_FREQ[k];
            end
        end
        return f;
    endfunction

    assign req.ready = !full;
    assign accept    = req.valid && req.ready;
    assign rate      = rate_reg;

    always_comb
    begin
        count_clamped = (req.sample_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST)
                                                                 : req.sample_count;
        off_sum = {1'b0, offset_reg} + SUM_W'(count_clamped);
        span    = SUM_W'(rate_reg) * SUM_W'(WRAP_SECONDS);

        push              = accept && (mask_reg != '0) && (count_clamped != '0);
        push_cmd.base     = offset_reg;
        push_cmd.count    = count_clamped;
        push_cmd.row_freq = pick_freq(mask_reg[3:0], 1'b0);
        push_cmd.col_freq = pick_freq(mask_reg[7:4], 1'b1);

        offset_next = offset_reg;
        if (accept && (mask_reg != '0)) begin
            if (off_sum > span) begin
                offset_next = OFFSET_W'(off_sum - span);
            end else begin
                offset_next = off_sum[OFFSET_W-1:0];
            end
        end

        rate_next = rate_reg;
        mask_next = mask_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLE_RATE: rate_next = cfg_data[RATE_W-1:0];
                REG_TONE_MASK:   mask_next = cfg_data[MASK_W-1:0];
                default:         rate_next = rate_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rate_reg   <= RATE_RESET;
            mask_reg   <= '0;
            offset_reg <= '0;
        end else begin
            rate_reg   <= rate_next;
            mask_reg   <= mask_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== design/dtg_fifo.sv =====
// Two-entry command queue between the front end and the sample engine.
// Depends on dtg_pkg.
`timescale 1ns / 1ps

module dtg_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dtg_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output dtg_pkg::cmd_t  pop_cmd,
    output logic           empty
);
    import dtg_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/dtg_div.sv =====
// Bit-serial restoring divider, one dividend bit per cycle. Keeps the low
// QUO_W quotient bits and the full remainder. Depends on dtg_pkg.
`timescale 1ns / 1ps

module dtg_div #(
    parameter int DVD_W = 40,
    parameter int QUO_W = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DVD_W-1:0]               dividend,
    input  logic [dtg_pkg::RATE_W-1:0]     divisor,
    output logic                           done,
    output logic [QUO_W-1:0]               quotient,
    output logic [dtg_pkg::RATE_W-1:0]     remainder
);
    import dtg_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [RATE_W:0]     rem_shift;
    logic [RATE_W:0]     rem_sub;
    logic                fits;

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        // The partial remainder stays below the divisor, so one extra bit holds the shift.
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        fits      = (rem_shift >= {1'b0, divisor});
        rem_sub   = rem_shift - {1'b0, divisor};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = fits ? rem_sub[RATE_W-1:0] : rem_shift[RATE_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

// ===== design/dtg_back.sv =====
// Sample engine: per-burst phase setup through the serial divider, then a
// per-sample phase step, quarter-wave sine lookup and mixing into an output
// register. Depends on dtg_pkg, dtg_div and dtg_smp_if.
`timescale 1ns / 1ps

module dtg_back #(
    parameter int SINE_PHASE_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [dtg_pkg::RATE_W-1:0]     rate,
    input  logic                           empty,
    input  dtg_pkg::cmd_t                  pop_cmd,
    output logic                           pop,
    dtg_smp_if.source                      smp
);
    import dtg_pkg::*;

    localparam int PB     = SINE_PHASE_BITS;
    localparam int QTR    = 1 << (PB - 2);
    localparam int ADDR_W = PB - 1;
    localparam int DVD_W  = PROD_W + PB;
    localparam int MIX_W  = SAMPLE_W + 1;

    localparam longint unsigned SIN_A1 = 64'd1686629713;
    localparam longint unsigned SIN_A3 = 64'd693598669;
    localparam longint unsigned SIN_A5 = 64'd85569309;
    localparam longint unsigned SIN_A7 = 64'd5026995;
    localparam longint unsigned SIN_A9 = 64'd172272;

    typedef logic [ROM_W-1:0] sine_rom_t [QTR+1];

    // Odd polynomial in Q2.30, evaluated once per entry when the table is built.
    function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned u);
        longint unsigned x30;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned y;
        x30 = 64'(u) << (32 - PB);
        x2  = (x30 * x30) >> 30;
        t   = SIN_A9;
        t   = SIN_A7 - ((t * x2) >> 30);
        t   = SIN_A5 - ((t * x2) >> 30);
        t   = SIN_A3 - ((t * x2) >> 30);
        t   = SIN_A1 - ((t * x2) >> 30);
        y   = (t * x30) >> 30;
        y   = (y + 64'd32768) >> 16;
        if (y > 64'(SAMPLE_MAX)) begin
            y = 64'(SAMPLE_MAX);
        end
        return ROM_W'(y);
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t rom;
        for (int k = 0; k <= QTR; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 tone_reg, tone_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [PB-1:0]        idx_reg [2];
    logic [PB-1:0]        idx_next [2];
    logic [RATE_W-1:0]    rem_reg [2];
    logic [RATE_W-1:0]    rem_next [2];
    logic [PB-1:0]        dq_reg [2];
    logic [PB-1:0]        dq_next [2];
    logic [RATE_W-1:0]    dr_reg [2];
    logic [RATE_W-1:0]    dr_next [2];
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [SAMPLE_W-1:0]  row_val_reg, row_val_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]  out_sample_reg, out_sample_next;
    logic                 out_last_reg, out_last_next;
    logic [ROM_W-1:0]     rom_q_reg;
    logic                 rom_neg_reg;

    logic [FREQ_W-1:0]    tone_freq;
    logic                 div_start, div_done;
    logic [DVD_W-1:0]     div_dividend;
    logic [PB-1:0]        div_quo;
    logic [RATE_W-1:0]    div_rem;
    logic                 rom_en;
    logic [PB-1:0]        rd_idx;
    logic [ADDR_W-1:0]    rd_off;
    logic [ADDR_W-1:0]    rom_addr;
    logic [SAMPLE_W-1:0]  rom_mag, rom_val;
    logic                 row_on, col_on;
    logic [SAMPLE_W-1:0]  col_val;
    logic signed [MIX_W-1:0] mix_sum, mix_adj, mix_half;
    logic [RATE_W:0]      adv_sum [2];
    logic                 adv_wrap [2];
    logic [RATE_W-1:0]    adv_rem [2];
    logic [PB-1:0]        adv_idx [2];

    dtg_div #(
        .DVD_W (DVD_W),
        .QUO_W (PB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (rate),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign smp.valid  = out_valid_reg;
    assign smp.sample = out_sample_reg;
    assign smp.last   = out_last_reg;

    assign tone_freq = tone_reg ? cmd_reg.col_freq : cmd_reg.row_freq;
    assign div_dividend = (state_reg == BK_POS_START) ? {prod_reg, {PB{1'b0}}}
                                                      : DVD_W'({tone_freq, {PB{1'b0}}});

    // Quadrant from the top two index bits; odd quadrants read the mirrored entry.
    assign rd_idx   = (state_reg == BK_COL) ? idx_reg[1] : idx_reg[0];
    assign rd_off   = ADDR_W'(rd_idx[PB-3:0]);
    assign rom_addr = rd_idx[PB-2] ? (ADDR_W'(QTR) - rd_off) : rd_off;
    assign rom_mag  = SAMPLE_W'(rom_q_reg);
    assign rom_val  = rom_neg_reg ? (SAMPLE_W'(0) - rom_mag) : rom_mag;

    // A zero rate or a silent half gives zero for that tone.
    assign row_on  = (cmd_reg.row_freq != '0) && (rate != '0);
    assign col_on  = (cmd_reg.col_freq != '0) && (rate != '0);
    assign col_val = col_on ? rom_val : '0;

    always_comb
    begin
        mix_sum  = MIX_W'(signed'(row_val_reg)) + MIX_W'(signed'(col_val));
        mix_adj  = mix_sum + MIX_W'(mix_sum[MIX_W-1]);
        mix_half = mix_adj >>> 1;
    end

    // Phase advance per sample: remainder and divided step both stay below the rate.
    always_comb
    begin
        for (int k = 0; k < 2; k++) begin
            adv_sum[k]  = {1'b0, rem_reg[k]} + {1'b0, dr_reg[k]};
            adv_wrap[k] = (adv_sum[k] >= {1'b0, rate});
            adv_rem[k]  = adv_wrap[k] ? RATE_W'(adv_sum[k] - {1'b0, rate})
                                      : adv_sum[k][RATE_W-1:0];
            adv_idx[k]  = idx_reg[k] + dq_reg[k] + PB'(adv_wrap[k]);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        tone_next       = tone_reg;
        prod_next       = prod_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        dr_next         = dr_reg;
        left_next       = left_reg;
        row_val_next    = row_val_reg;
        out_valid_next  = out_valid_reg && !smp.ready;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        div_start       = 1'b0;
        rom_en          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!empty) begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    tone_next  = 1'b0;
                    left_next  = pop_cmd.count;
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                prod_next  = PROD_W'(tone_freq) * PROD_W'(cmd_reg.base);
                state_next = BK_POS_START;
            end
            BK_POS_START:
            begin
                div_start  = 1'b1;
                state_next = BK_POS_WAIT;
            end
            BK_POS_WAIT:
            begin
                if (div_done) begin
                    idx_next[tone_reg] = div_quo;
                    rem_next[tone_reg] = div_rem;
                    state_next         = BK_STEP_START;
                end
            end
            BK_STEP_START:
            begin
                div_start  = 1'b1;
                state_next = BK_STEP_WAIT;
            end
            BK_STEP_WAIT:
            begin
                if (div_done) begin
                    dq_next[tone_reg] = div_quo;
                    dr_next[tone_reg] = div_rem;
                    if (!tone_reg) begin
                        tone_next  = 1'b1;
                        state_next = BK_MUL;
                    end else begin
                        state_next = BK_ROW;
                    end
                end
            end
            BK_ROW:
            begin
                rom_en     = 1'b1;
                state_next = BK_COL;
            end
            BK_COL:
            begin
                rom_en       = 1'b1;
                row_val_next = row_on ? rom_val : '0;
                state_next   = BK_MIX;
            end
            BK_MIX:
            begin
                if (!out_valid_reg || smp.ready) begin
                    out_valid_next  = 1'b1;
                    out_sample_next = mix_half[SAMPLE_W-1:0];
                    out_last_next   = (left_reg == COUNT_W'(1));
                    left_next       = left_reg - 1'b1;
                    for (int k = 0; k < 2; k++) begin
                        idx_next[k] = adv_idx[k];
                        rem_next[k] = adv_rem[k];
                    end
                    state_next = (left_reg == COUNT_W'(1)) ? BK_IDLE : BK_ROW;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        tone_reg       <= tone_next;
        prod_reg       <= prod_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        dq_reg         <= dq_next;
        dr_reg         <= dr_next;
        left_reg       <= left_next;
        row_val_reg    <= row_val_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (rom_en) begin
            rom_q_reg   <= SINE_ROM[rom_addr];
            rom_neg_reg <= rd_idx[PB-1];
        end
    end

endmodule

// ===== design/dtmf_tone_generator.sv =====
// DTMF dual-tone generator, top level.
// Depends on dtg_pkg, dtg_req_if, dtg_smp_if, dtg_front, dtg_fifo and dtg_back.
//
// Usage:
//   Configuration goes through cfg_wr_en / cfg_index / cfg_data: sample rate and
//   tone mask, written while no burst is outstanding. A transfer on req asks for a
//   burst of sample_count samples (clamped to MAX_BURST); smp delivers one transfer
//   per sample, with last set on the final one. With a zero tone mask a request
//   produces nothing and the sample counter holds; a zero count produces nothing.
//   Requests land in a two-entry command queue, so req stays ready while the
//   engine works, until two bursts are waiting.
//   Sequence: each burst first takes the queue entry and sets up both tone phases
//   with a bit-serial divider, then emits its samples one after another, each going
//   through row lookup, column lookup and mix on the single sine table port. The
//   engine takes the next queue entry only once the last sample of a burst is loaded.
//   The result sits in an output register; while smp is stalled the engine holds
//   the next sample and resumes as soon as the register is taken.
//   Reset clears the counter, the queue and the output valid flag, loads the sample
//   rate with 44100 and the mask with zero. There is no clearing pass.
`timescale 1ns / 1ps

module dtmf_tone_generator #(
    parameter int SINE_PHASE_BITS = 10,
    parameter int MAX_BURST       = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  dtg_pkg::cfg_reg_t                  cfg_index,
    input  logic [dtg_pkg::CFG_DATA_W-1:0]     cfg_data,
    dtg_req_if.sink                            req,
    dtg_smp_if.source                          smp
);
    import dtg_pkg::*;

    logic              full, empty, push, pop;
    cmd_t              push_cmd, pop_cmd;
    logic [RATE_W-1:0] rate;

    dtg_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .full      (full),
        .push      (push),
        .push_cmd  (push_cmd),
        .rate      (rate)
    );

    dtg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    dtg_back #(
        .SINE_PHASE_BITS (SINE_PHASE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rate    (rate),
        .empty   (empty),
        .pop_cmd (pop_cmd),
        .pop     (pop),
        .smp     (smp)
    );

endmodule

// ===== design/dtg_checker.sv =====
// Port-level checks for the DTMF tone generator, bound to the top level.
// Depends on dtg_pkg and dtmf_tone_generator.
`timescale 1ns / 1ps

module dtg_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           smp_valid,
    input  logic                           smp_ready,
    input  logic [dtg_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           last
);
    import dtg_pkg::*;

    // The output valid flag is cleared asynchronously.
    a_reset_clears: assert property (@(posedge clk) !rst_n |-> !smp_valid)
        else $error("sample valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_ready |=> smp_valid && $stable(sample) && $stable(last))
        else $error("stalled sample changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid |-> ($signed(sample) >= -SAMPLE_MAX) && ($signed(sample) <= SAMPLE_MAX))
        else $error("sample out of range");

endmodule

bind dtmf_tone_generator dtg_checker u_dtg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp.valid),
    .smp_ready (smp.ready),
    .sample    (smp.sample),
    .last      (smp.last)
);
